// ----- hw/rtl/cart_bank_pcm_scanline_irq_defines.svh -----
// ---------------------------------------------------------------------------
// cart_bank_pcm_scanline_irq_defines.svh
// Assertion macros for the cartridge mapper.
// ---------------------------------------------------------------------------
`ifndef CART_BANK_PCM_SCANLINE_IRQ_DEFINES_SVH
`define CART_BANK_PCM_SCANLINE_IRQ_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CBPSI_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock edge.
`define CBPSI_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cbpsi_pkg.sv -----
// ---------------------------------------------------------------------------
// cbpsi_pkg
// Widths, codes and address helpers of the cartridge mapper.
// ---------------------------------------------------------------------------
package cbpsi_pkg;

  localparam int PRG_BANK_BITS    = 6;
  localparam int CHR_BANK_BITS    = 6;
  localparam int SAMPLE_ADDR_BITS = 22;
  localparam int REPEAT_WINDOW    = 4;

  localparam int ROM_W  = 22;
  localparam int BANK_W = 6;
  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CHR   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PRG    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHR    = 3'd4;

  // Write decode on address bits 15..12
  localparam logic [3:0] WR_RELOAD  = 4'h8;
  localparam logic [3:0] WR_CLEAR   = 4'h9;
  localparam logic [3:0] WR_DISABLE = 4'hA;
  localparam logic [3:0] WR_ENABLE  = 4'hB;
  localparam logic [3:0] WR_SERIAL  = 4'hC;
  localparam logic [3:0] WR_AUTOINC = 4'hD;
  localparam logic [3:0] WR_BANK_LO = 4'hE;
  localparam logic [3:0] WR_BANK_HI = 4'hF;

  // Fixed banks
  localparam logic [7:0] PRG_FIX_5000 = 8'h01;
  localparam logic [7:0] PRG_FIX_D000 = 8'h07;
  localparam logic [7:0] PRG_FIX_E000 = 8'h04;
  localparam logic [7:0] CHR_FIX_1000 = 8'hFD;

  localparam logic [7:0] PRG8_MASK = 8'((1 << PRG_BANK_BITS) - 1);
  localparam logic [7:0] PRG4_MASK = 8'((1 << (PRG_BANK_BITS + 1)) - 1);
  localparam logic [7:0] CHR_MASK  = 8'((1 << CHR_BANK_BITS) - 1);
  localparam logic [ROM_W-1:0] SAMPLE_MASK = ROM_W'((64'd1 << SAMPLE_ADDR_BITS) - 64'd1);

  function automatic logic [ROM_W-1:0] prg8(input logic [7:0] bank,
                                            input logic [15:0] addr);
    logic [ROM_W-1:0] b;
    b = ROM_W'(bank & PRG8_MASK);
    return (b << 13) | ROM_W'(addr[12:0]);
  endfunction

  function automatic logic [ROM_W-1:0] prg4(input logic [7:0] bank,
                                            input logic [15:0] addr);
    logic [ROM_W-1:0] b;
    b = ROM_W'(bank & PRG4_MASK);
    return (b << 12) | ROM_W'(addr[11:0]);
  endfunction

  function automatic logic [ROM_W-1:0] chr4(input logic [7:0] bank,
                                            input logic [15:0] addr);
    logic [ROM_W-1:0] b;
    b = ROM_W'(bank & CHR_MASK);
    return (b << 12) | ROM_W'(addr[11:0]);
  endfunction

endpackage

// ----- hw/rtl/cart_bank_pcm_scanline_irq.sv -----
// ---------------------------------------------------------------------------
// cart_bank_pcm_scanline_irq
// Cartridge bank mapper with serial sample port and scanline IRQ.
// ---------------------------------------------------------------------------
// Each transfer on the input side (CPU write, CPU read, pattern read or
// scanline tick) gives exactly one result: the kind of access, the byte
// address in the selected ROM and the IRQ line after the item. The block
// takes one item per cycle unless the output stalls, and its result is
// registered: register updates and address mapping are done in one pass
// from the input ports into the result register, and a new item is taken
// whenever the result register is empty or its result is taken in the same
// cycle. A repeated sample read of the same address less than REPEAT_WINDOW
// after it in cycle_stamp returns open bus and leaves the sample state alone.
// ROM data and the open-bus byte are supplied outside the block.
// ---------------------------------------------------------------------------
`include "cart_bank_pcm_scanline_irq_defines.svh"

module cart_bank_pcm_scanline_irq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic [15:0]                     bus_address,
  input  logic [7:0]                      write_data,
  input  logic [31:0]                     cycle_stamp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cbpsi_pkg::KIND_W-1:0]    access_kind,
  output logic [cbpsi_pkg::ROM_W-1:0]     rom_address,
  output logic                            irq_line
);
  import cbpsi_pkg::*;

  logic [BANK_W-1:0] bank_regs [4];
  logic [7:0]        irq_counter;
  logic [7:0]        irq_reload_value;
  logic              irq_enabled;
  logic              irq_pending;
  logic [ROM_W-1:0]  sample_address;
  logic              auto_increment;
  logic [15:0]       last_read_address;
  logic [31:0]       last_read_stamp;

  logic [7:0]        irq_counter_next;
  logic [7:0]        irq_reload_value_next;
  logic              irq_enabled_next;
  logic              irq_pending_next;
  logic [ROM_W-1:0]  sample_address_next;
  logic              auto_increment_next;
  logic [15:0]       last_read_address_next;
  logic [31:0]       last_read_stamp_next;
  logic              bank_we;
  logic [1:0]        bank_idx;

  logic              accept;
  logic [KIND_W-1:0] kind;
  logic [ROM_W-1:0]  rom;
  logic              sample_hit;
  logic              repeat_read;
  logic [31:0]       stamp_diff;
  logic [7:0]        tick_count;
  logic              is_disable;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign sample_hit = (bus_address[15:11] == 5'b01001) ||
                      (bus_address[15:12] == WR_SERIAL);
  assign stamp_diff = cycle_stamp - last_read_stamp;
  assign repeat_read = (bus_address == last_read_address) &&
                       (stamp_diff < 32'(REPEAT_WINDOW));
  assign tick_count = (irq_counter == 8'd0) ? irq_reload_value : irq_counter - 8'd1;
  assign is_disable = (cmd_t'(command) == CMD_WRITE) && bus_address[15] &&
                      (bus_address[15:12] == WR_DISABLE);
  assign bank_idx   = write_data[7:6];

  always_comb begin
    irq_counter_next       = irq_counter;
    irq_reload_value_next  = irq_reload_value;
    irq_enabled_next       = irq_enabled;
    irq_pending_next       = irq_pending;
    sample_address_next    = sample_address;
    auto_increment_next    = auto_increment;
    last_read_address_next = last_read_address;
    last_read_stamp_next   = last_read_stamp;
    bank_we                = 1'b0;
    kind                   = KIND_NONE;
    rom                    = '0;

    unique case (cmd_t'(command))
      CMD_WRITE: begin
        if (bus_address[15]) begin
          unique case (bus_address[15:12])
            WR_RELOAD:  irq_reload_value_next = write_data;
            WR_CLEAR:   irq_counter_next = 8'd0;
            WR_DISABLE: begin
              irq_enabled_next = 1'b0;
              irq_pending_next = 1'b0;
            end
            WR_ENABLE:  irq_enabled_next = 1'b1;
            WR_SERIAL:  sample_address_next = {sample_address[ROM_W-2:0], write_data[7]};
            WR_AUTOINC: auto_increment_next = write_data[1];
            WR_BANK_LO, WR_BANK_HI: bank_we = 1'b1;
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (sample_hit) begin
          if (repeat_read) begin
            kind = KIND_OPEN;
          end else begin
            kind = KIND_SAMPLE;
            rom  = sample_address & SAMPLE_MASK;
            if (auto_increment) sample_address_next = sample_address + ROM_W'(1);
            last_read_address_next = bus_address;
            last_read_stamp_next   = cycle_stamp;
          end
        end else if (bus_address >= 16'h5000) begin
          kind = KIND_PRG;
          priority if (bus_address < 16'h6000) rom = prg4(PRG_FIX_5000, bus_address);
          else if (bus_address < 16'h8000) rom = prg8(8'(bank_regs[0]), bus_address);
          else if (bus_address < 16'hA000) rom = prg8(8'(bank_regs[1]), bus_address);
          else if (bus_address < 16'hC000) rom = prg8(8'(bank_regs[2]), bus_address);
          else if (bus_address < 16'hE000) rom = prg4(PRG_FIX_D000, bus_address);
          else rom = prg8(PRG_FIX_E000, bus_address);
        end
      end
      CMD_CHR: begin
        kind = KIND_CHR;
        rom  = chr4(bus_address[12] ? CHR_FIX_1000 : 8'(bank_regs[3]), bus_address);
      end
      CMD_TICK: begin
        irq_counter_next = tick_count;
        if (tick_count == 8'd0 && irq_enabled) irq_pending_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) bank_regs[i] <= '0;
      irq_counter       <= '0;
      irq_reload_value  <= '0;
      irq_enabled       <= 1'b0;
      irq_pending       <= 1'b0;
      sample_address    <= '0;
      auto_increment    <= 1'b0;
      last_read_address <= '0;
      last_read_stamp   <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        if (bank_we) bank_regs[bank_idx] <= write_data[BANK_W-1:0];
        irq_counter       <= irq_counter_next;
        irq_reload_value  <= irq_reload_value_next;
        irq_enabled       <= irq_enabled_next;
        irq_pending       <= irq_pending_next;
        sample_address    <= sample_address_next;
        auto_increment    <= auto_increment_next;
        last_read_address <= last_read_address_next;
        last_read_stamp   <= last_read_stamp_next;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      access_kind <= kind;
      rom_address <= rom;
      irq_line    <= irq_pending_next;
    end
  end

  `CBPSI_CHECK(a_irq_line_tracks, out_valid |-> (irq_line == irq_pending), "irq_line out of step with pending state")
  `CBPSI_CHECK(a_open_bus_zero, (out_valid && access_kind == KIND_OPEN) |-> (rom_address == '0), "open bus result carries an address")
  `CBPSI_CHECK(a_pending_needs_enable, $rose(irq_pending) |-> irq_enabled, "IRQ raised while disabled")
  `CBPSI_CHECK(a_pending_clear_cause, $fell(irq_pending) |-> ($past(rst) || $past(accept && is_disable)), "IRQ dropped without a disable write")
  `CBPSI_CHECK_NEXT(a_accept_gives_result, accept, out_valid, "accepted item left no result")

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the cart_bank_pcm_scanline_irq cartridge mapper.
// ---------------------------------------------------------------------------
// Drives CPU writes, CPU reads, pattern reads and scanline ticks through the
// valid/stall input channel and predicts the kind, ROM address and IRQ line
// of every result with its own model of the banks, serial sample port and
// scanline counter. A directed opening hits the address map edges, the
// open-bus repeat window (including stamp wrap) and the IRQ sequence; a
// random part follows, with idle bursts on both channels.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpsi_pkg::*;

  localparam int QUIET_LIMIT  = 200;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROM_W-1:0]  rom;
    logic              irq;
  } mapper_result_t;

  // Mapper state mirror and queue of expected results.
  class mapper_checker;
    logic [BANK_W-1:0] bank_reg [4];
    logic [7:0]        line_count;
    logic [7:0]        reload_val;
    bit                irq_en;
    bit                irq_pend;
    logic [ROM_W-1:0]  sample_ptr;
    bit                auto_inc;
    logic [15:0]       last_addr;
    logic [31:0]       last_stamp;
    mapper_result_t    expected_access_q [$];
    int errors, results;
    int n_write, n_read, n_sample, n_open, n_chr, n_tick, n_irq;

    function new();
      foreach (bank_reg[i]) bank_reg[i] = '0;
      line_count = '0;
      reload_val = '0;
      irq_en     = 0;
      irq_pend   = 0;
      sample_ptr = '0;
      auto_inc   = 0;
      last_addr  = '0;
      last_stamp = '0;
    endfunction

    function logic [ROM_W-1:0] rom_window(logic [7:0] bank, int bank_bits,
                                          int page_bits, logic [15:0] addr);
      int unsigned b, off;
      b   = 32'(bank) & ((32'd1 << bank_bits) - 32'd1);
      off = 32'(addr) & ((32'd1 << page_bits) - 32'd1);
      return ROM_W'((b << page_bits) | off);
    endfunction

    function void note_transfer(cmd_t cmd, logic [15:0] addr, logic [7:0] data,
                                logic [31:0] stamp);
      mapper_result_t r;
      logic [31:0] age;
      r.kind = KIND_NONE;
      r.rom  = '0;
      case (cmd)
        CMD_WRITE: begin
          n_write++;
          if (addr[15]) begin
            case (addr[15:12])
              WR_RELOAD:  reload_val = data;
              WR_CLEAR:   line_count = '0;
              WR_DISABLE: begin
                irq_en   = 0;
                irq_pend = 0;
              end
              WR_ENABLE:  irq_en = 1;
              WR_SERIAL:  sample_ptr = {sample_ptr[ROM_W-2:0], data[7]};
              WR_AUTOINC: auto_inc = data[1];
              WR_BANK_LO, WR_BANK_HI: bank_reg[data[7:6]] = data[5:0];
              default: ;
            endcase
          end
        end
        CMD_READ: begin
          n_read++;
          if ((addr >= 16'h4800 && addr < 16'h5000) || addr[15:12] == 4'hC) begin
            age = stamp - last_stamp;
            if (addr == last_addr && age < 32'(REPEAT_WINDOW)) begin
              r.kind = KIND_OPEN;
              n_open++;
            end else begin
              r.kind = KIND_SAMPLE;
              r.rom  = ROM_W'(32'(sample_ptr) & ((32'd1 << SAMPLE_ADDR_BITS) - 32'd1));
              if (auto_inc) sample_ptr = sample_ptr + ROM_W'(1);
              last_addr  = addr;
              last_stamp = stamp;
              n_sample++;
            end
          end else if (addr >= 16'h5000) begin
            r.kind = KIND_PRG;
            if (addr < 16'h6000)
              r.rom = rom_window(PRG_FIX_5000, PRG_BANK_BITS + 1, 12, addr);
            else if (addr < 16'h8000)
              r.rom = rom_window(8'(bank_reg[0]), PRG_BANK_BITS, 13, addr);
            else if (addr < 16'hA000)
              r.rom = rom_window(8'(bank_reg[1]), PRG_BANK_BITS, 13, addr);
            else if (addr < 16'hC000)
              r.rom = rom_window(8'(bank_reg[2]), PRG_BANK_BITS, 13, addr);
            else if (addr < 16'hE000)
              r.rom = rom_window(PRG_FIX_D000, PRG_BANK_BITS + 1, 12, addr);
            else
              r.rom = rom_window(PRG_FIX_E000, PRG_BANK_BITS, 13, addr);
          end
        end
        CMD_CHR: begin
          n_chr++;
          r.kind = KIND_CHR;
          r.rom  = rom_window(addr[12] ? CHR_FIX_1000 : {2'b00, bank_reg[3]},
                              CHR_BANK_BITS, 12, addr);
        end
        default: begin
          n_tick++;
          if (line_count == 8'd0) line_count = reload_val;
          else                    line_count = line_count - 8'd1;
          if (line_count == 8'd0 && irq_en) begin
            if (!irq_pend) n_irq++;
            irq_pend = 1;
          end
        end
      endcase
      r.irq = irq_pend;
      expected_access_q.push_back(r);
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [ROM_W-1:0] rom,
                               logic irq);
      mapper_result_t want;
      if (expected_access_q.size() == 0) begin
        $error("result with no transfer pending: kind %0d address %06h", kind, rom);
        errors++;
        return;
      end
      want = expected_access_q.pop_front();
      results++;
      if (kind !== want.kind) begin
        $error("access_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (rom !== want.rom) begin
        $error("rom_address: expected %06h, actual %06h", want.rom, rom);
        errors++;
      end
      if (irq !== want.irq) begin
        $error("irq_line: expected %0b, actual %0b", want.irq, irq);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           command;
  logic [15:0]          bus_address;
  logic [7:0]           write_data;
  logic [31:0]          cycle_stamp;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    access_kind;
  logic [ROM_W-1:0]     rom_address;
  logic                 irq_line;

  mapper_checker checker_h;
  bit            idling;
  int            quiet_cycles;
  int            stall_left;
  logic [31:0]   cpu_cycle;
  logic [15:0]   recent_sample_addr;

  cart_bank_pcm_scanline_irq dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .bus_address (bus_address),
    .write_data  (write_data),
    .cycle_stamp (cycle_stamp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .access_kind (access_kind),
    .rom_address (rom_address),
    .irq_line    (irq_line)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Note the input first so a result in the same cycle as its input would still find its entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        checker_h.note_transfer(cmd_t'(command), bus_address, write_data, cycle_stamp);
      if (out_valid && !out_stall)
        checker_h.check_result(access_kind, rom_address, irq_line);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else                                                    quiet_cycles++;
    end
  end

  // Result side: random stall bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (idling && $urandom_range(0, 6) == 0) stall_left <= $urandom_range(1, 4);
    end
  end

  initial begin
    wait (rst === 1'b0);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("cart_bank_pcm_scanline_irq test failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(cmd_t cmd, logic [15:0] addr, logic [7:0] data,
                           logic [31:0] stamp);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    = 1'b1;
    command     = cmd;
    bus_address = addr;
    write_data  = data;
    cycle_stamp = stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (checker_h.expected_access_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int          sel;
    logic [3:0]  nib;
    logic [15:0] addr;
    logic [7:0]  data;
    cmd_t        cmd;
    sel  = $urandom_range(0, 99);
    data = 8'($urandom());
    if ($urandom_range(0, 6) == 0) cpu_cycle = $urandom();
    else                           cpu_cycle = cpu_cycle + $urandom_range(0, 5);
    if (sel < 30) begin
      cmd  = CMD_WRITE;
      nib  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 7))
                                         : 4'($urandom_range(8, 15));
      addr = {nib, 12'($urandom())};
      // keep reloads short so the scanline IRQ fires often
      if (nib == WR_RELOAD && $urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 4));
    end else if (sel < 65) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 1) == 1) addr = recent_sample_addr;
        else if ($urandom_range(0, 1) == 1) addr = {5'b01001, 11'($urandom())};
        else addr = {4'hC, 12'($urandom())};
        recent_sample_addr = addr;
      end else begin
        addr = 16'($urandom());
      end
    end else if (sel < 80) begin
      cmd  = CMD_CHR;
      addr = 16'($urandom());
    end else begin
      cmd  = CMD_TICK;
      addr = 16'($urandom());
    end
    send_item(cmd, addr, data, cpu_cycle);
  endtask

  initial begin
    checker_h          = new();
    rst                = 1'b1;
    in_valid           = 1'b0;
    command            = CMD_WRITE;
    bus_address        = '0;
    write_data         = '0;
    cycle_stamp        = '0;
    out_stall          = 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    idling             = 0;
    cpu_cycle          = 32'd1000;
    recent_sample_addr = 16'h4800;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // serial sample port, auto-increment and the repeat window
    send_item(CMD_WRITE, 16'hC000, 8'h80, 32'd0);
    send_item(CMD_WRITE, 16'hCFFF, 8'h00, 32'd0);
    send_item(CMD_WRITE, 16'hD000, 8'h02, 32'd0);
    send_item(CMD_READ,  16'h4800, 8'h00, 32'd100);
    send_item(CMD_READ,  16'h4800, 8'h00, 32'd103);
    send_item(CMD_READ,  16'h4800, 8'h00, 32'd104);
    send_item(CMD_READ,  16'hC123, 8'h00, 32'd105);
    send_item(CMD_WRITE, 16'hDFFF, 8'hFD, 32'd0);
    send_item(CMD_READ,  16'hCFFF, 8'h00, 32'hFFFF_FFFE);
    send_item(CMD_READ,  16'hCFFF, 8'hFF, 32'h0000_0001);
    // bank registers, then every window of the read map
    send_item(CMD_WRITE, 16'hE000, 8'h3F, 32'd0);
    send_item(CMD_WRITE, 16'hFFFF, 8'h6A, 32'd0);
    send_item(CMD_WRITE, 16'hF000, 8'hBF, 32'd0);
    send_item(CMD_WRITE, 16'hE5A5, 8'hC1, 32'd0);
    send_item(CMD_WRITE, 16'h7FFF, 8'hFF, 32'd0);
    send_item(CMD_READ,  16'h5000, 8'h00, 32'd0);
    send_item(CMD_READ,  16'h7FFF, 8'h00, 32'd0);
    send_item(CMD_READ,  16'h8000, 8'h00, 32'd0);
    send_item(CMD_READ,  16'hBFFF, 8'h00, 32'd0);
    send_item(CMD_READ,  16'hD000, 8'h00, 32'd0);
    send_item(CMD_READ,  16'hFFFF, 8'h00, 32'd0);
    send_item(CMD_READ,  16'h47FF, 8'h00, 32'd0);
    send_item(CMD_CHR,   16'h0000, 8'h00, 32'd0);
    send_item(CMD_CHR,   16'hFFFF, 8'h00, 32'd0);
    // scanline IRQ: reload, enable, count down, clear, disable
    send_item(CMD_WRITE, 16'h8000, 8'h02, 32'd0);
    send_item(CMD_WRITE, 16'hB000, 8'h00, 32'd0);
    repeat (3) send_item(CMD_TICK, 16'h0000, 8'h00, 32'd0);
    send_item(CMD_WRITE, 16'h9000, 8'h00, 32'd0);
    send_item(CMD_TICK,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, 16'hA000, 8'h00, 32'd0);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling = (i < 500) || (i >= 650 && i < 1000);
      if (i == 600) drain_results();
      random_item();
    end

    in_valid = 1'b0;
    while (checker_h.expected_access_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (checker_h.expected_access_q.size() != 0) begin
      $error("%0d expected results never arrived", checker_h.expected_access_q.size());
      checker_h.errors++;
    end
    $display("Covered %0d results: %0d writes, %0d reads (%0d sample, %0d open bus),",
             checker_h.results, checker_h.n_write, checker_h.n_read,
             checker_h.n_sample, checker_h.n_open);
    $display("  %0d pattern reads, %0d scanline ticks, %0d IRQ assertions.",
             checker_h.n_chr, checker_h.n_tick, checker_h.n_irq);
    if (checker_h.errors == 0)
      $display("cart_bank_pcm_scanline_irq test passed");
    else
      $display("cart_bank_pcm_scanline_irq test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/cbpsi_pkg.sv
hw/rtl/cart_bank_pcm_scanline_irq.sv
sim/testbench.sv
